@@ rtl/pcft_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pcft_pkg;

    localparam int MODE_W  = 8;
    localparam int TICKS_W = 16;
    localparam int CFG_IDX_W = 2;

    // Number of per-channel mode fields carried by a request.
    localparam int MODE_FIELDS = 4;

    localparam logic [MODE_W-1:0] MODE_OFF    = 8'd0;
    localparam logic [MODE_W-1:0] MODE_EMATCH = 8'd1;
    localparam logic [MODE_W-1:0] MODE_TALON  = 8'd2;
    localparam logic [MODE_W-1:0] MODE_METRON = 8'd3;

    localparam int TICK_MS   = 10;
    localparam int EMATCH_MS = 1500;
    localparam int TALON_MS  = 3000;
    localparam int METRON_MS = 500;

    localparam logic [TICKS_W-1:0] EMATCH_TICKS_RST = TICKS_W'(EMATCH_MS / TICK_MS);
    localparam logic [TICKS_W-1:0] TALON_TICKS_RST  = TICKS_W'(TALON_MS / TICK_MS);
    localparam logic [TICKS_W-1:0] METRON_TICKS_RST = TICKS_W'(METRON_MS / TICK_MS);

    localparam logic [CFG_IDX_W-1:0] CFG_EMATCH_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TALON_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_METRON_TICKS = 2'd2;

    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [MODE_W-1:0] mode_ch0;
        logic [MODE_W-1:0] mode_ch1;
        logic [MODE_W-1:0] mode_ch2;
        logic [MODE_W-1:0] mode_ch3;
        logic              armed;
    } pcft_req_t;

    typedef struct packed {
        logic [3:0]        line_levels;
        logic [MODE_W-1:0] state_ch0;
        logic [MODE_W-1:0] state_ch1;
        logic [MODE_W-1:0] state_ch2;
        logic [MODE_W-1:0] state_ch3;
        logic              report_now;
    } pcft_res_t;

    // Burn durations shared by every channel lane.
    typedef struct packed {
        logic [TICKS_W-1:0] ematch_ticks;
        logic [TICKS_W-1:0] talon_ticks;
        logic [TICKS_W-1:0] metron_ticks;
    } pcft_cfg_t;

    // What one lane reports to the merge stage: values after the request.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              line;
        logic              expired;
    } pcft_lane_t;

endpackage

`default_nettype wire

@@ rtl/pcft_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcft_lane (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic                      tick,
    input  wire logic                      armed,
    input  wire logic [pcft_pkg::MODE_W-1:0] mode_in,
    input  wire pcft_pkg::pcft_cfg_t       cfg,
    output pcft_pkg::pcft_lane_t           status
);
    import pcft_pkg::*;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [TICKS_W-1:0] time_left_reg, time_left_next;
    logic               running_reg, running_next;
    logic               line_reg, line_next;
    logic               expired;
    logic               start;
    logic [TICKS_W-1:0] duration;

    always_comb
    begin
        mode_next      = mode_reg;
        time_left_next = time_left_reg;
        running_next   = running_reg;
        line_next      = line_reg;
        expired        = 1'b0;
        start          = 1'b0;
        duration       = cfg.ematch_ticks;
        if (tick == REQ_COMMAND)
        begin
            mode_next = armed ? mode_in : MODE_OFF;
        end
        else
        begin
            // Count down first; an expiring timer turns the channel off.
            if (running_reg)
            begin
                if (time_left_reg <= TICKS_W'(1))
                begin
                    time_left_next = '0;
                    running_next   = 1'b0;
                    mode_next      = MODE_OFF;
                    expired        = 1'b1;
                end
                else
                begin
                    time_left_next = time_left_reg - TICKS_W'(1);
                end
            end
            if (!armed || mode_next == MODE_OFF)
            begin
                line_next = 1'b0;
            end
            else
            begin
                unique case (mode_next)
                    MODE_EMATCH:
                    begin
                        line_next = 1'b1;
                        start     = 1'b1;
                        duration  = cfg.ematch_ticks;
                    end
                    MODE_TALON:
                    begin
                        line_next = 1'b1;
                        start     = 1'b1;
                        duration  = cfg.talon_ticks;
                    end
                    MODE_METRON:
                    begin
                        line_next = !line_reg;
                        start     = 1'b1;
                        duration  = cfg.metron_ticks;
                    end
                    default:
                    begin
                        // Unknown modes keep the line level and start no timer.
                        line_next = line_reg;
                    end
                endcase
            end
            if (start && !running_next)
            begin
                time_left_next = duration;
                running_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            time_left_reg <= '0;
            running_reg   <= 1'b0;
            line_reg      <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            time_left_reg <= time_left_next;
            running_reg   <= running_next;
            line_reg      <= line_next;
        end
    end

    assign status.mode    = mode_next;
    assign status.line    = line_next;
    assign status.expired = expired;

endmodule

`default_nettype wire

@@ rtl/pcft_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcft_merge #(
    parameter int CHANNELS = 4
) (
    input  wire logic                 tick,
    input  wire pcft_pkg::pcft_lane_t lanes [CHANNELS],
    output pcft_pkg::pcft_res_t       res
);
    import pcft_pkg::*;

    logic [MODE_W-1:0] state [MODE_FIELDS];
    logic [3:0]        lines;
    logic              any_expired;

    for (genvar k = 0; k < MODE_FIELDS; k++)
    begin : g_field
        if (k < CHANNELS)
        begin : g_live
            assign state[k] = lanes[k].mode;
            assign lines[k] = lanes[k].line;
        end
        else
        begin : g_absent
            assign state[k] = MODE_OFF;
            assign lines[k] = 1'b0;
        end
    end

    always_comb
    begin
        any_expired = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            any_expired = any_expired | lanes[i].expired;
        end
    end

    assign res.line_levels = lines;
    assign res.state_ch0   = state[0];
    assign res.state_ch1   = state[1];
    assign res.state_ch2   = state[2];
    assign res.state_ch3   = state[3];
    // Every command is reported; a tick only when some timer ran out.
    assign res.report_now  = (tick == REQ_COMMAND) | any_expired;

endmodule

`default_nettype wire

@@ rtl/pyro_channel_fire_timer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------
// request   | req_valid / req_ready  | req_data (pcft_req_t)
// result    | res_valid / res_ready  | res_data (pcft_res_t)
// config    | cfg_we (no wait)       | cfg_index, cfg_data (16 bit)
//
// Every request produces exactly one result, registered in the cycle after the
// request is taken. All channel lanes update in parallel, so a new request is
// taken every cycle as long as the result register is empty or being drained.
// A stall on the result side holds the result register and lowers req_ready.
// Reset clears all channel state and loads the default burn durations.

module pyro_channel_fire_timer_unit #(
    parameter int CHANNELS = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire pcft_pkg::pcft_req_t            req_data,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output pcft_pkg::pcft_res_t                 res_data,
    input  wire logic                           cfg_we,
    input  wire logic [pcft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pcft_pkg::TICKS_W-1:0]   cfg_data
);
    import pcft_pkg::*;

    // Configuration registers. The user must see that they are only written while the block
    // is idle, so the lanes read them directly; the block itself does not enforce this.
    pcft_cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EMATCH_TICKS: cfg_next.ematch_ticks = cfg_data;
                CFG_TALON_TICKS:  cfg_next.talon_ticks  = cfg_data;
                CFG_METRON_TICKS: cfg_next.metron_ticks = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ematch_ticks <= EMATCH_TICKS_RST;
            cfg_reg.talon_ticks  <= TALON_TICKS_RST;
            cfg_reg.metron_ticks <= METRON_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The request is taken whenever the result register can accept the
    // result it produces in the same cycle.
    logic accept;
    assign req_ready = !res_valid || res_ready;
    assign accept    = req_valid && req_ready;

    // Mode fields of the request, indexed by channel. Channels beyond the
    // fields that a request carries always receive the off mode.
    logic [MODE_W-1:0] req_modes [MODE_FIELDS];
    assign req_modes[0] = req_data.mode_ch0;
    assign req_modes[1] = req_data.mode_ch1;
    assign req_modes[2] = req_data.mode_ch2;
    assign req_modes[3] = req_data.mode_ch3;

    pcft_lane_t lanes [CHANNELS];

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        logic [MODE_W-1:0] lane_mode;
        if (i < MODE_FIELDS)
        begin : g_fed
            assign lane_mode = req_modes[i];
        end
        else
        begin : g_unfed
            assign lane_mode = MODE_OFF;
        end

        pcft_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .accept  (accept),
            .tick    (req_data.req_type),
            .armed   (req_data.armed),
            .mode_in (lane_mode),
            .cfg     (cfg_reg),
            .status  (lanes[i])
        );
    end

    // Merge the lane outcomes into one result item.
    pcft_res_t merged;

    pcft_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .tick  (req_data.req_type),
        .lanes (lanes),
        .res   (merged)
    );

    // Result register. The payload needs no reset; only the valid flag does.
    pcft_res_t res_reg;
    logic      res_valid_reg, res_valid_next;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= merged;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef NO_ASSERTIONS
    // A taken request always leaves a result waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid)
        else $error("result missing after an accepted request");

    // Every command request is reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_data.req_type == REQ_COMMAND |=> res_data.report_now)
        else $error("command request not reported");

    // A tick while disarmed drives every fire line low.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_data.req_type == REQ_TICK && !req_data.armed
        |=> res_data.line_levels == 4'd0)
        else $error("fire line high after a disarmed tick");

    // A disarmed command leaves channel 0 off.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_data.req_type == REQ_COMMAND && !req_data.armed
        |=> res_data.state_ch0 == MODE_OFF)
        else $error("channel mode stored by a disarmed command");
`endif

endmodule

`default_nettype wire
